@@ rtl/adam_optimizer_update_top_macros.svh @@
// Assertion macros shared by the Adam update RTL.
`ifndef ADAM_OPTIMIZER_UPDATE_TOP_MACROS_SVH
`define ADAM_OPTIMIZER_UPDATE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ADAMU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ADAMU_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADAMU_ASSERT(lbl, clk, rst_n, prop, msg)
`define ADAMU_ASSERT_ANY(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/adamu_pkg.sv @@
// Types and constants shared by the Adam update block.
`timescale 1ns / 1ps
package adamu_pkg;

    localparam int STEP_BITS   = 20;
    localparam int STEP_IDX_W  = $clog2(STEP_BITS);
    localparam int INDEX_W     = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_PASS   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_LEARN_RATE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_DECAY  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_DECAY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EPSILON      = 3'd3;

    localparam logic [31:0] RST_LEARN_RATE   = 32'd16777;
    localparam logic [15:0] RST_FIRST_DECAY  = 16'd58982;
    localparam logic [15:0] RST_SECOND_DECAY = 16'd65470;
    localparam logic [31:0] RST_EPSILON      = 32'd43;

    localparam logic [33:0] DELTA_CAP = 34'h2_0000_0000;

    typedef struct packed {
        logic                        action;
        logic [INDEX_W-1:0]          element_index;
        logic [STEP_BITS-1:0]        update_number;
        logic signed [31:0]          weight_value;
        logic signed [31:0]          gradient_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_weight;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic [31:0] learn_rate;
        logic [15:0] first_decay;
        logic [15:0] second_decay;
        logic [31:0] epsilon;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        in_item_t   item;
    } queue_entry_t;

    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } fifo_head_t;

    typedef struct packed {
        logic pop;
        logic init_done;
    } back_ctrl_t;

endpackage

@@ rtl/adamu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module adamu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/adamu_front.sv @@
// Input side: accepts items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`include "adam_optimizer_update_top_macros.svh"
module adamu_front #(
    parameter int MOMENT_DEPTH = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  adamu_pkg::in_item_t    item,
    input  adamu_pkg::back_ctrl_t  ctrl,
    output adamu_pkg::fifo_head_t  head
);
    import adamu_pkg::*;

    queue_entry_t        q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                push;
    logic                full;
    queue_entry_t        new_entry;

    assign full       = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign item_ready = ctrl.init_done && !full;
    assign push       = item_valid && item_ready;

    always_comb
    begin
        new_entry.item = item;
        if (32'(item.element_index) >= 32'(MOMENT_DEPTH))
        begin
            new_entry.kind = KIND_PASS;
        end
        else if (item.action == ACT_CLEAR)
        begin
            new_entry.kind = KIND_CLEAR;
        end
        else
        begin
            new_entry.kind = KIND_UPDATE;
        end
    end

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = ctrl.pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(ctrl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= new_entry;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = q_reg[rptr_reg];

    `ADAMU_ASSERT(a_pop_not_empty, clk, rst_n, ctrl.pop |-> count_reg != '0, "pop from empty queue")
    `ADAMU_ASSERT(a_count_bound, clk, rst_n, count_reg <= (QPTR_W + 1)'(QDEPTH), "queue overfilled")

endmodule

@@ rtl/adamu_back.sv @@
// Execution side: moment store, rate cache, shared multiplier, square root and divider.
`timescale 1ns / 1ps
`include "adam_optimizer_update_top_macros.svh"
module adamu_back #(
    parameter int MOMENT_DEPTH = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  adamu_pkg::cfg_t        cfg,
    input  adamu_pkg::fifo_head_t  head,
    output adamu_pkg::back_ctrl_t  ctrl,
    output logic                   result_valid,
    input  logic                   result_ready,
    output adamu_pkg::out_item_t   result
);
    import adamu_pkg::*;

    localparam int ADDR_W = $clog2(MOMENT_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MOMENT_DEPTH - 1);

    localparam logic [4:0] S_INIT      = 5'd0;
    localparam logic [4:0] S_IDLE      = 5'd1;
    localparam logic [4:0] S_POW_MUL   = 5'd2;
    localparam logic [4:0] S_POW_SQ    = 5'd3;
    localparam logic [4:0] S_POW_BASE  = 5'd4;
    localparam logic [4:0] S_RATE_MUL  = 5'd5;
    localparam logic [4:0] S_RATE_DIV  = 5'd6;
    localparam logic [4:0] S_SQRT      = 5'd7;
    localparam logic [4:0] S_DIV       = 5'd8;
    localparam logic [4:0] S_RD        = 5'd9;
    localparam logic [4:0] S_LOAD      = 5'd10;
    localparam logic [4:0] S_E1        = 5'd11;
    localparam logic [4:0] S_E2        = 5'd12;
    localparam logic [4:0] S_E3        = 5'd13;
    localparam logic [4:0] S_E4        = 5'd14;
    localparam logic [4:0] S_E5        = 5'd15;
    localparam logic [4:0] S_E6        = 5'd16;
    localparam logic [4:0] S_E7        = 5'd17;
    localparam logic [4:0] S_E8        = 5'd18;
    localparam logic [4:0] S_POSTSQRT  = 5'd19;
    localparam logic [4:0] S_Q1        = 5'd20;
    localparam logic [4:0] S_Q2        = 5'd21;
    localparam logic [4:0] S_Q3        = 5'd22;
    localparam logic [4:0] S_FIN       = 5'd23;

    logic [4:0]             state_reg, state_next;
    logic [ADDR_W-1:0]      init_addr_reg, init_addr_next;
    in_item_t               item_reg, item_next;
    logic [STEP_BITS-1:0]   cached_step_reg, cached_step_next;
    logic [31:0]            cached_rate_reg, cached_rate_next;
    logic [31:0]            pow_r_reg, pow_r_next;
    logic                   pow_one_reg, pow_one_next;
    logic [31:0]            pow_base_reg, pow_base_next;
    logic [STEP_IDX_W-1:0]  pow_bit_reg, pow_bit_next;
    logic                   pow_sel_reg, pow_sel_next;
    logic [31:0]            s_reg, s_next;
    logic                   s_full_reg, s_full_next;
    logic [32:0]            d1_reg, d1_next;
    logic signed [65:0]     prod_reg, prod_next;
    logic signed [65:0]     acc_reg, acc_next;
    logic [31:0]            m_reg, m_next;
    logic [63:0]            v_reg, v_next;
    logic [63:0]            g2_reg, g2_next;
    logic [63:0]            hi_reg, hi_next;
    logic [63:0]            sq_x_reg, sq_x_next;
    logic [63:0]            sq_r_reg, sq_r_next;
    logic [63:0]            sq_bit_reg, sq_bit_next;
    logic [5:0]             iter_reg, iter_next;
    logic                   ret_rate_reg, ret_rate_next;
    logic [63:0]            dv_num_reg, dv_num_next;
    logic [48:0]            dv_rem_reg, dv_rem_next;
    logic [48:0]            dv_den_reg, dv_den_next;
    logic [33:0]            delta_reg, delta_next;
    logic                   res_valid_reg, res_valid_next;
    out_item_t              res_reg, res_next;

    logic signed [32:0]     mul_a, mul_b;
    logic                   ram_we, ram_re;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [31:0]            ram_m_wdata, ram_m_rdata;
    logic [63:0]            ram_v_wdata, ram_v_rdata;

    in_item_t               head_item;
    logic [ADDR_W-1:0]      head_addr, item_addr;
    logic                   slot_free;
    logic                   head_pop;
    logic [31:0]            g_abs, m_mag;
    logic [16:0]            c1, c2;
    logic [63:0]            sq_sum, sq_r_step, sq_x_step;
    logic                   sq_ge;
    logic [49:0]            dv_sh;
    logic                   dv_ge;
    logic [48:0]            dv_rem_step;
    logic [63:0]            dv_num_step;
    logic signed [65:0]     e_sum;
    logic [63:0]            v_new;
    logic [48:0]            den;
    logic [40:0]            dl_sum;
    logic [33:0]            delta_q;
    logic [35:0]            fin_sum;
    logic                   fin_sat;
    logic [63:0]            pow_x;
    logic                   pow_t_bit;

    assign head_item = head.entry.item;
    assign head_addr = ADDR_W'(head_item.element_index);
    assign item_addr = ADDR_W'(item_reg.element_index);
    assign slot_free = !res_valid_reg || result_ready;

    assign g_abs = item_reg.gradient_value[31] ? 32'd0 - item_reg.gradient_value
                                                : item_reg.gradient_value;
    assign m_mag = m_reg[31] ? 32'd0 - m_reg : m_reg;
    assign c1    = 17'h10000 - {1'b0, cfg.first_decay};
    assign c2    = 17'h10000 - {1'b0, cfg.second_decay};

    // One step of the bit-pair square root.
    assign sq_sum    = sq_r_reg + sq_bit_reg;
    assign sq_ge     = (sq_x_reg >= sq_sum);
    assign sq_r_step = sq_ge ? (sq_r_reg >> 1) + sq_bit_reg : sq_r_reg >> 1;
    assign sq_x_step = sq_ge ? sq_x_reg - sq_sum : sq_x_reg;

    // One step of the restoring divider; the dividend shifts out as the quotient shifts in.
    assign dv_sh       = {dv_rem_reg, dv_num_reg[63]};
    assign dv_ge       = (dv_sh >= {1'b0, dv_den_reg});
    assign dv_rem_step = dv_ge ? 49'(dv_sh - {1'b0, dv_den_reg}) : dv_sh[48:0];
    assign dv_num_step = {dv_num_reg[62:0], dv_ge};

    assign e_sum = acc_reg + prod_reg;
    assign v_new = {hi_reg[47:0], 16'd0} + {16'd0, e_sum[63:16]};
    assign den   = {1'b0, sq_r_reg[31:0], 16'd0} + {17'd0, cfg.epsilon};

    assign dl_sum  = {1'b0, hi_reg[31:0], 8'd0} + {1'b0, prod_reg[63:24]};
    assign delta_q = ((hi_reg[63:32] != 32'd0) || (dl_sum > 41'(DELTA_CAP)))
                     ? DELTA_CAP : dl_sum[33:0];

    assign fin_sum = m_reg[31]
                     ? {{4{item_reg.weight_value[31]}}, item_reg.weight_value} + {2'd0, delta_reg}
                     : {{4{item_reg.weight_value[31]}}, item_reg.weight_value} - {2'd0, delta_reg};
    assign fin_sat = (fin_sum[35:31] != 5'b00000) && (fin_sum[35:31] != 5'b11111);

    // 2^32 minus the power, shifted up by 32, as the square root operand.
    assign pow_x     = pow_one_reg ? 64'd0 : {32'd0 - pow_r_reg, 32'd0};
    assign pow_t_bit = item_reg.update_number[pow_bit_reg];

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        state_next       = state_reg;
        init_addr_next   = init_addr_reg;
        item_next        = item_reg;
        cached_step_next = cached_step_reg;
        cached_rate_next = cached_rate_reg;
        pow_r_next       = pow_r_reg;
        pow_one_next     = pow_one_reg;
        pow_base_next    = pow_base_reg;
        pow_bit_next     = pow_bit_reg;
        pow_sel_next     = pow_sel_reg;
        s_next           = s_reg;
        s_full_next      = s_full_reg;
        d1_next          = d1_reg;
        acc_next         = acc_reg;
        m_next           = m_reg;
        v_next           = v_reg;
        g2_next          = g2_reg;
        hi_next          = hi_reg;
        sq_x_next        = sq_x_reg;
        sq_r_next        = sq_r_reg;
        sq_bit_next      = sq_bit_reg;
        iter_next        = iter_reg;
        ret_rate_next    = ret_rate_reg;
        dv_num_next      = dv_num_reg;
        dv_rem_next      = dv_rem_reg;
        dv_den_next      = dv_den_reg;
        delta_next       = delta_reg;
        res_next         = res_reg;
        res_valid_next   = (res_valid_reg && result_ready) ? 1'b0 : res_valid_reg;
        head_pop         = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = item_addr;
        ram_m_wdata      = 32'd0;
        ram_v_wdata      = 64'd0;
        ram_re           = 1'b0;
        mul_a            = '0;
        mul_b            = '0;

        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = init_addr_reg;
                if (init_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_addr_next = init_addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (head.valid && slot_free)
                begin
                    head_pop  = 1'b1;
                    item_next = head_item;
                    case (head.entry.kind)
                        KIND_UPDATE:
                        begin
                            if (head_item.update_number == cached_step_reg)
                            begin
                                state_next = S_RD;
                            end
                            else if (head_item.update_number == '0)
                            begin
                                cached_rate_next = 32'd0;
                                cached_step_next = '0;
                                state_next       = S_RD;
                            end
                            else
                            begin
                                pow_one_next  = 1'b1;
                                pow_base_next = {cfg.second_decay, 16'd0};
                                pow_bit_next  = '0;
                                pow_sel_next  = 1'b0;
                                state_next    = S_POW_MUL;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            ram_we                = 1'b1;
                            ram_waddr             = head_addr;
                            res_next.new_weight   = head_item.weight_value;
                            res_next.saturated    = 1'b0;
                            res_valid_next        = 1'b1;
                        end
                        default:
                        begin
                            res_next.new_weight   = head_item.weight_value;
                            res_next.saturated    = 1'b0;
                            res_valid_next        = 1'b1;
                        end
                    endcase
                end
            end
            S_POW_MUL:
            begin
                mul_a      = {1'b0, pow_r_reg};
                mul_b      = {1'b0, pow_base_reg};
                state_next = S_POW_SQ;
            end
            S_POW_SQ:
            begin
                if (pow_t_bit)
                begin
                    pow_one_next = 1'b0;
                    pow_r_next   = pow_one_reg ? pow_base_reg : prod_reg[63:32];
                end
                mul_a      = {1'b0, pow_base_reg};
                mul_b      = {1'b0, pow_base_reg};
                state_next = S_POW_BASE;
            end
            S_POW_BASE:
            begin
                pow_base_next = prod_reg[63:32];
                if (pow_bit_reg != STEP_IDX_W'(STEP_BITS - 1))
                begin
                    pow_bit_next = pow_bit_reg + 1'b1;
                    state_next   = S_POW_MUL;
                end
                else if (!pow_sel_reg)
                begin
                    // Second decay power finished: bias correction numerator next.
                    if (!pow_one_reg && (pow_r_reg == 32'd0))
                    begin
                        s_full_next   = 1'b1;
                        pow_one_next  = 1'b1;
                        pow_base_next = {cfg.first_decay, 16'd0};
                        pow_bit_next  = '0;
                        pow_sel_next  = 1'b1;
                        state_next    = S_POW_MUL;
                    end
                    else
                    begin
                        s_full_next   = 1'b0;
                        sq_x_next     = pow_x;
                        sq_r_next     = 64'd0;
                        sq_bit_next   = 64'h4000_0000_0000_0000;
                        iter_next     = 6'd31;
                        ret_rate_next = 1'b1;
                        state_next    = S_SQRT;
                    end
                end
                else if (pow_one_reg)
                begin
                    cached_rate_next = 32'd0;
                    cached_step_next = item_reg.update_number;
                    state_next       = S_RD;
                end
                else
                begin
                    d1_next    = 33'h1_0000_0000 - {1'b0, pow_r_reg};
                    state_next = S_RATE_MUL;
                end
            end
            S_RATE_MUL:
            begin
                mul_a      = {1'b0, cfg.learn_rate};
                mul_b      = {1'b0, s_reg};
                state_next = S_RATE_DIV;
            end
            S_RATE_DIV:
            begin
                dv_num_next   = s_full_reg ? {cfg.learn_rate, 32'd0} : prod_reg[63:0];
                dv_rem_next   = 49'd0;
                dv_den_next   = {16'd0, d1_reg};
                iter_next     = 6'd63;
                ret_rate_next = 1'b1;
                state_next    = S_DIV;
            end
            S_SQRT:
            begin
                sq_x_next   = sq_x_step;
                sq_r_next   = sq_r_step;
                sq_bit_next = sq_bit_reg >> 2;
                iter_next   = iter_reg - 1'b1;
                if (iter_reg == 6'd0)
                begin
                    if (ret_rate_reg)
                    begin
                        s_next        = sq_r_step[31:0];
                        pow_one_next  = 1'b1;
                        pow_base_next = {cfg.first_decay, 16'd0};
                        pow_bit_next  = '0;
                        pow_sel_next  = 1'b1;
                        state_next    = S_POW_MUL;
                    end
                    else
                    begin
                        state_next = S_POSTSQRT;
                    end
                end
            end
            S_DIV:
            begin
                dv_num_next = dv_num_step;
                dv_rem_next = dv_rem_step;
                iter_next   = iter_reg - 1'b1;
                if (iter_reg == 6'd0)
                begin
                    if (ret_rate_reg)
                    begin
                        cached_rate_next = (dv_num_step[63:32] != 32'd0)
                                           ? 32'hFFFF_FFFF : dv_num_step[31:0];
                        cached_step_next = item_reg.update_number;
                        state_next       = S_RD;
                    end
                    else
                    begin
                        state_next = S_Q1;
                    end
                end
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                m_next     = ram_m_rdata;
                v_next     = ram_v_rdata;
                state_next = S_E1;
            end
            S_E1:
            begin
                mul_a      = {17'd0, cfg.first_decay};
                mul_b      = {m_reg[31], m_reg};
                state_next = S_E2;
            end
            S_E2:
            begin
                acc_next   = prod_reg;
                mul_a      = {16'd0, c1};
                mul_b      = {item_reg.gradient_value[31], item_reg.gradient_value};
                state_next = S_E3;
            end
            S_E3:
            begin
                m_next     = e_sum[47:16];
                mul_a      = {1'b0, g_abs};
                mul_b      = {1'b0, g_abs};
                state_next = S_E4;
            end
            S_E4:
            begin
                g2_next    = prod_reg[63:0];
                mul_a      = {17'd0, cfg.second_decay};
                mul_b      = {1'b0, v_reg[63:32]};
                state_next = S_E5;
            end
            S_E5:
            begin
                acc_next   = prod_reg;
                mul_a      = {16'd0, c2};
                mul_b      = {1'b0, g2_reg[63:32]};
                state_next = S_E6;
            end
            S_E6:
            begin
                hi_next    = e_sum[63:0];
                mul_a      = {17'd0, cfg.second_decay};
                mul_b      = {1'b0, v_reg[31:0]};
                state_next = S_E7;
            end
            S_E7:
            begin
                acc_next   = prod_reg;
                mul_a      = {16'd0, c2};
                mul_b      = {1'b0, g2_reg[31:0]};
                state_next = S_E8;
            end
            S_E8:
            begin
                v_next        = v_new;
                ram_we        = 1'b1;
                ram_m_wdata   = m_reg;
                ram_v_wdata   = v_new;
                sq_x_next     = v_new;
                sq_r_next     = 64'd0;
                sq_bit_next   = 64'h4000_0000_0000_0000;
                iter_next     = 6'd31;
                ret_rate_next = 1'b0;
                state_next    = S_SQRT;
            end
            S_POSTSQRT:
            begin
                if (den == 49'd0)
                begin
                    delta_next = (m_mag == 32'd0) ? 34'd0 : DELTA_CAP;
                    state_next = S_FIN;
                end
                else
                begin
                    dv_num_next   = {m_mag, 32'd0};
                    dv_rem_next   = 49'd0;
                    dv_den_next   = den;
                    iter_next     = 6'd63;
                    ret_rate_next = 1'b0;
                    state_next    = S_DIV;
                end
            end
            S_Q1:
            begin
                mul_a      = {1'b0, cached_rate_reg};
                mul_b      = {1'b0, dv_num_reg[63:32]};
                state_next = S_Q2;
            end
            S_Q2:
            begin
                hi_next    = prod_reg[63:0];
                mul_a      = {1'b0, cached_rate_reg};
                mul_b      = {1'b0, dv_num_reg[31:0]};
                state_next = S_Q3;
            end
            S_Q3:
            begin
                delta_next = delta_q;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    if (fin_sat)
                    begin
                        res_next.new_weight = fin_sum[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end
                    else
                    begin
                        res_next.new_weight = fin_sum[31:0];
                    end
                    res_next.saturated = fin_sat;
                    res_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            init_addr_reg   <= '0;
            item_reg        <= '0;
            cached_step_reg <= '0;
            cached_rate_reg <= '0;
            pow_r_reg       <= '0;
            pow_one_reg     <= 1'b0;
            pow_base_reg    <= '0;
            pow_bit_reg     <= '0;
            pow_sel_reg     <= 1'b0;
            s_reg           <= '0;
            s_full_reg      <= 1'b0;
            d1_reg          <= '0;
            prod_reg        <= '0;
            acc_reg         <= '0;
            m_reg           <= '0;
            v_reg           <= '0;
            g2_reg          <= '0;
            hi_reg          <= '0;
            sq_x_reg        <= '0;
            sq_r_reg        <= '0;
            sq_bit_reg      <= '0;
            iter_reg        <= '0;
            ret_rate_reg    <= 1'b0;
            dv_num_reg      <= '0;
            dv_rem_reg      <= '0;
            dv_den_reg      <= '0;
            delta_reg       <= '0;
            res_valid_reg   <= 1'b0;
            res_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            init_addr_reg   <= init_addr_next;
            item_reg        <= item_next;
            cached_step_reg <= cached_step_next;
            cached_rate_reg <= cached_rate_next;
            pow_r_reg       <= pow_r_next;
            pow_one_reg     <= pow_one_next;
            pow_base_reg    <= pow_base_next;
            pow_bit_reg     <= pow_bit_next;
            pow_sel_reg     <= pow_sel_next;
            s_reg           <= s_next;
            s_full_reg      <= s_full_next;
            d1_reg          <= d1_next;
            prod_reg        <= prod_next;
            acc_reg         <= acc_next;
            m_reg           <= m_next;
            v_reg           <= v_next;
            g2_reg          <= g2_next;
            hi_reg          <= hi_next;
            sq_x_reg        <= sq_x_next;
            sq_r_reg        <= sq_r_next;
            sq_bit_reg      <= sq_bit_next;
            iter_reg        <= iter_next;
            ret_rate_reg    <= ret_rate_next;
            dv_num_reg      <= dv_num_next;
            dv_rem_reg      <= dv_rem_next;
            dv_den_reg      <= dv_den_next;
            delta_reg       <= delta_next;
            res_valid_reg   <= res_valid_next;
            res_reg         <= res_next;
        end
    end

    adamu_ram #(
        .WIDTH (32),
        .DEPTH (MOMENT_DEPTH)
    ) u_first_moment (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_m_wdata),
        .re    (ram_re),
        .raddr (item_addr),
        .rdata (ram_m_rdata)
    );

    adamu_ram #(
        .WIDTH (64),
        .DEPTH (MOMENT_DEPTH)
    ) u_second_moment (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_v_wdata),
        .re    (ram_re),
        .raddr (item_addr),
        .rdata (ram_v_rdata)
    );

    assign ctrl           = '{pop: head_pop, init_done: (state_reg != S_INIT)};
    assign result_valid   = res_valid_reg;
    assign result         = res_reg;

    `ADAMU_ASSERT(a_rate_current, clk, rst_n, state_reg == S_LOAD |-> cached_step_reg == item_reg.update_number, "rate cache stale at moment load")
    `ADAMU_ASSERT(a_div_nonzero, clk, rst_n, state_reg == S_DIV |-> dv_den_reg != '0, "divide by zero")

endmodule

@@ rtl/adam_optimizer_update_top.sv @@
// Top level of the fixed-point Adam update block: configuration registers and the two halves.
`timescale 1ns / 1ps
// Each transfer on item either updates one element's moments and returns the new weight,
// clears one element's moments, or (for an index at or beyond MOMENT_DEPTH) returns the
// weight unchanged; every item produces exactly one result transfer. A four-entry queue
// takes items while the back end works. An update runs a 32-step square root and, unless
// the denominator is zero, a 64-step divider, in turn under one state machine; when the
// step number is nonzero and differs from the cached one, the bias-corrected rate is
// recomputed first. After reset the moment store is zeroed by a sweep over every address,
// during which no item is taken; configuration writes land at once and should be made
// only while the block is idle.
module adam_optimizer_update_top #(
    parameter int MOMENT_DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  adamu_pkg::in_item_t                    item,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output adamu_pkg::out_item_t                   result,
    input  logic                                   cfg_we,
    input  logic [adamu_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [31:0]                            cfg_data
);
    import adamu_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    fifo_head_t  head;
    back_ctrl_t  ctrl;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LEARN_RATE:   cfg_next.learn_rate   = cfg_data;
                REG_FIRST_DECAY:  cfg_next.first_decay  = cfg_data[15:0];
                REG_SECOND_DECAY: cfg_next.second_decay = cfg_data[15:0];
                REG_EPSILON:      cfg_next.epsilon      = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.learn_rate   <= RST_LEARN_RATE;
            cfg_reg.first_decay  <= RST_FIRST_DECAY;
            cfg_reg.second_decay <= RST_SECOND_DECAY;
            cfg_reg.epsilon      <= RST_EPSILON;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    adamu_front #(
        .MOMENT_DEPTH (MOMENT_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .ctrl       (ctrl),
        .head       (head)
    );

    adamu_back #(
        .MOMENT_DEPTH (MOMENT_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .ctrl         (ctrl),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

@@ dv/adam_update_checker.sv @@
// Checker for the Adam update block: predicts each result and compares it with the output.
`timescale 1ns / 1ps
module adam_update_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_ready,
    input  adamu_pkg::in_item_t  item,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  adamu_pkg::out_item_t result,
    input  logic                 cfg_we,
    input  logic [adamu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   fail_count,
    output int                   pending_count
);
    import adamu_pkg::*;

    localparam int DEPTH = 4096;
    localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

    logic [31:0] lr_q;
    logic [15:0] b1_q;
    logic [15:0] b2_q;
    logic [31:0] eps_q;
    logic [31:0] m_mem [DEPTH];
    logic [63:0] v_mem [DEPTH];
    logic [STEP_BITS-1:0] rate_step;
    logic [31:0] rate_val;
    out_item_t expected_weights[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= r + bitv)
            begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] decay_power(input logic [15:0] b,
                                                input logic [STEP_BITS-1:0] t);
        logic [63:0] r;
        logic [63:0] base;
        r = ONE_Q32;
        base = {32'd0, b, 16'd0};
        for (int i = 0; i < STEP_BITS; i++)
        begin
            if (t[i])
                r = (r * base) >> 32;
            base = (base * base) >> 32;
        end
        return r;
    endfunction

    function automatic logic [31:0] bias_rate(input logic [STEP_BITS-1:0] t);
        logic [63:0] n2;
        logic [63:0] s;
        logic [63:0] d1;
        logic [95:0] prod;
        logic [95:0] q;
        if (t == 0)
            return 0;
        n2 = ONE_Q32 - decay_power(b2_q, t);
        s = (n2 >= ONE_Q32) ? ONE_Q32 : int_sqrt(n2 << 32);
        d1 = ONE_Q32 - decay_power(b1_q, t);
        if (d1 == 0)
            return 0;
        prod = {64'd0, lr_q} * {32'd0, s};
        q = prod / {32'd0, d1};
        return (q > 96'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic out_item_t adam_step(input in_item_t it);
        out_item_t o;
        logic signed [63:0] w;
        logic signed [63:0] g;
        logic signed [63:0] m;
        logic signed [63:0] res;
        logic [63:0] v;
        logic [63:0] g2;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] mag;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] delta;
        logic [63:0] c1;
        logic [63:0] c2;
        w = it.weight_value;
        g = it.gradient_value;
        o.new_weight = it.weight_value;
        o.saturated = 1'b0;
        if (it.element_index >= DEPTH)
            return o;
        if (it.action == ACT_CLEAR)
        begin
            m_mem[it.element_index] = 0;
            v_mem[it.element_index] = 0;
            return o;
        end
        if (it.update_number != rate_step)
        begin
            rate_val = bias_rate(it.update_number);
            rate_step = it.update_number;
        end
        c1 = 64'd65536 - b1_q;
        m = $signed(m_mem[it.element_index]);
        m = ($signed({48'd0, b1_q}) * m + $signed(c1) * g) >>> 16;
        m_mem[it.element_index] = m[31:0];
        c2 = 64'd65536 - b2_q;
        v = v_mem[it.element_index];
        g2 = g * g;
        hi = b2_q * (v >> 32) + c2 * (g2 >> 32);
        lo = b2_q * v[31:0] + c2 * g2[31:0];
        v = (hi << 16) + (lo >> 16);
        v_mem[it.element_index] = v;
        mag = (m < 0) ? -m : m;
        den = (int_sqrt(v) << 16) + eps_q;
        if (den == 0)
            delta = (mag == 0) ? 0 : 64'(DELTA_CAP);
        else
        begin
            q = (mag << 32) / den;
            hi = rate_val * (q >> 32);
            lo = rate_val * q[31:0];
            if (hi >= ONE_Q32)
                delta = 64'(DELTA_CAP);
            else
                delta = (hi << 8) + (lo >> 24);
            if (delta > 64'(DELTA_CAP))
                delta = 64'(DELTA_CAP);
        end
        res = (m < 0) ? w + $signed(delta) : w - $signed(delta);
        if (res > 64'sd2147483647)
        begin
            res = 64'sd2147483647;
            o.saturated = 1'b1;
        end
        else if (res < -64'sd2147483648)
        begin
            res = -64'sd2147483648;
            o.saturated = 1'b1;
        end
        o.new_weight = res[31:0];
        return o;
    endfunction

    assign pending_count = expected_weights.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_res;
        if (!rst_n)
        begin
            lr_q = RST_LEARN_RATE;
            b1_q = RST_FIRST_DECAY;
            b2_q = RST_SECOND_DECAY;
            eps_q = RST_EPSILON;
            rate_step = 0;
            rate_val = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                m_mem[i] = 0;
                v_mem[i] = 0;
            end
            expected_weights.delete();
            fail_count = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_weights.size() == 0)
                begin
                    $error("unexpected result transfer new_weight=%0d", result.new_weight);
                    fail_count++;
                end
                else
                begin
                    exp_res = expected_weights.pop_front();
                    if (result.new_weight !== exp_res.new_weight)
                    begin
                        $error("new_weight expected %0d actual %0d",
                               exp_res.new_weight, result.new_weight);
                        fail_count++;
                    end
                    if (result.saturated !== exp_res.saturated)
                    begin
                        $error("saturated expected %0b actual %0b",
                               exp_res.saturated, result.saturated);
                        fail_count++;
                    end
                end
            end
            if (item_valid && item_ready)
                expected_weights.insert(expected_weights.size(), adam_step(item));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LEARN_RATE:   lr_q = cfg_data;
                    REG_FIRST_DECAY:  b1_q = cfg_data[15:0];
                    REG_SECOND_DECAY: b2_q = cfg_data[15:0];
                    REG_EPSILON:      eps_q = cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

@@ dv/tb_adam_optimizer_update_top.sv @@
// Testbench top for the Adam update block: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module tb_adam_optimizer_update_top;
    import adamu_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNKNOWN = 3'd7;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    in_item_t item;
    logic result_valid;
    logic result_ready;
    out_item_t result;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0] cfg_data;
    int fail_count;
    int pending_count;
    logic [STEP_BITS-1:0] train_step;

    adam_optimizer_update_top uut (.*);

    adam_update_checker checker_inst (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // The receiver drops ready at random, drawn anew on every falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if ($urandom_range(0, 3) == 0)
            result_ready <= 1'b1;
        else
            result_ready <= ($urandom_range(0, 2) != 0) ? 1'b1 : ($urandom_range(0, 1) == 1);
    end

    // Valid stays high after a transfer so the next item can follow at once;
    // the gap and drain tasks drop it.
    task automatic send_item(input in_item_t it);
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_burst_gap();
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : 0;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        // Let the back end finish any rate recompute before touching registers.
        repeat (400) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic in_item_t make_update(input int idx,
                                             input int t,
                                             input logic [31:0] w,
                                             input logic [31:0] g);
        in_item_t it;
        it.action = ACT_UPDATE;
        it.element_index = INDEX_W'(idx);
        it.update_number = STEP_BITS'(t);
        it.weight_value = w;
        it.gradient_value = g;
        return it;
    endfunction

    task automatic random_phase(input int count);
        in_item_t it;
        int sel;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            // Mostly a training sequence: steps advance slowly over a small set of elements.
            if ($urandom_range(0, 15) == 0)
                train_step = train_step + 1'b1;
            it = make_update($urandom_range(0, 15), int'(train_step), $urandom, $urandom);
            if (sel < 15)
                it.gradient_value = $signed($urandom_range(0, 2000)) - 1000;
            else if (sel < 22)
                it.element_index = INDEX_W'($urandom);
            else if (sel < 27)
                it.action = ACT_CLEAR;
            else if (sel < 30)
                it.update_number = STEP_BITS'($urandom);
            else if (sel < 33)
                it.weight_value = $urandom_range(0, 1) ? 32'h7FFF_FFF0 : 32'h8000_0010;
            send_item(it);
            send_burst_gap();
        end
    endtask

    initial
    begin
        #10000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        in_item_t it;
        bit failed;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        train_step = STEP_BITS'(1);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, clears, the last index, step zero, step max.
        send_item(make_update(0, 1, 32'h0001_0000, 32'h0000_8000));
        send_item(make_update(0, 2, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(make_update(32'hFFF, 3, 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(make_update(1, 0, 32'h1234_5678, 32'hFFFF_FFFF));
        send_item(make_update(2, 32'hFFFFF, 32'hFFFF_FFFF, 32'h0000_0001));
        send_item(make_update(3, 32'hFFFFF, 32'h0, 32'h0));
        it = make_update(0, 1, 32'h5555_AAAA, 32'h0);
        it.action = ACT_CLEAR;
        send_item(it);
        send_item(make_update(0, 1, 32'hAAAA_5555, 32'h0));
        drain();

        // Zero denominator: epsilon zero and an untouched, zero gradient element.
        write_reg(REG_EPSILON, 32'd0);
        write_reg(REG_LEARN_RATE, 32'hFFFF_FFFF);
        write_reg(REG_FIRST_DECAY, 32'd0);
        write_reg(REG_SECOND_DECAY, 32'h0000_FFFF);
        write_reg(REG_UNKNOWN, 32'hDEAD_BEEF);
        send_item(make_update(20, 5, 32'h0, 32'h0));
        send_item(make_update(21, 6, 32'h7FFF_0000, 32'h0000_0003));
        send_item(make_update(22, 7, 32'h8000_0000, 32'hFFFF_FFFD));
        send_item(make_update(23, 1, 32'h0, 32'h7FFF_FFFF));
        drain();
        write_reg(REG_FIRST_DECAY, 32'h0000_FFFF);
        write_reg(REG_SECOND_DECAY, 32'd0);
        write_reg(REG_LEARN_RATE, 32'd0);
        send_item(make_update(24, 2, 32'h100, 32'h7FFF_FFFF));
        send_item(make_update(24, 3, 32'h100, 32'h8000_0000));
        drain();

        write_reg(REG_LEARN_RATE, 32'd16777);
        write_reg(REG_FIRST_DECAY, 32'd58982);
        write_reg(REG_SECOND_DECAY, 32'd65470);
        write_reg(REG_EPSILON, 32'd43);
        random_phase(350);
        drain();

        write_reg(REG_LEARN_RATE, $urandom);
        write_reg(REG_FIRST_DECAY, $urandom);
        write_reg(REG_SECOND_DECAY, $urandom);
        write_reg(REG_EPSILON, $urandom);
        random_phase(350);
        drain();

        write_reg(REG_LEARN_RATE, 32'h0100_0000);
        write_reg(REG_FIRST_DECAY, 32'd32768);
        write_reg(REG_SECOND_DECAY, 32'd65000);
        write_reg(REG_EPSILON, 32'hFFFF_FFFF);
        random_phase(350);
        drain();

        failed = (fail_count != 0);
        if (!failed)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
